// File: design/dmgl_pkg.sv
package dmgl_pkg;

   // Default grid limits; the top level hands these down as parameters.
   localparam int DEF_MAX_HALF_COLS = 64;
   localparam int DEF_MAX_HALF_ROWS = 64;

   // Register file: four registers, one word apart.
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_HALF_COLS = 2'd0;
   localparam logic [1:0] REG_HALF_ROWS = 2'd1;
   localparam logic [1:0] REG_CELL_SIZE = 2'd2;
   localparam logic [1:0] REG_OUTSIDE   = 2'd3;

   localparam logic [6:0]  RST_HALF_COLS = 7'd64;
   localparam logic [6:0]  RST_HALF_ROWS = 7'd64;
   localparam logic [9:0]  RST_CELL_SIZE = 10'd50;
   localparam logic [15:0] RST_OUTSIDE   = 16'd1000;

   // Item kinds.
   localparam logic [1:0] KIND_UPDATE  = 2'd0;
   localparam logic [1:0] KIND_COMPUTE = 2'd1;
   localparam logic [1:0] KIND_QUERY   = 2'd2;

   // Shared divider: for gradients the dividend holds mag*1024 + cell size, divisor 2*cell size.
   localparam int DIV_NUM_W = 29;
   localparam int DIV_DEN_W = 11;

   typedef struct packed {
      logic [1:0]         kind;
      logic [6:0]         col;
      logic [6:0]         row;
      logic [15:0]        cell_distance;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [15:0]        distance;
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
      logic               outside;
      logic               done_res;
   } rsp_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
      logic [DIV_DEN_W-1:0] rem;
   } div_res_type;

endpackage

// File: design/dmgl_div.sv
module dmgl_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dmgl_pkg::DIV_NUM_W-1:0]  num,
   input  logic [dmgl_pkg::DIV_DEN_W-1:0]  den,
   output dmgl_pkg::div_res_type           res
);
   import dmgl_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 take;

   // restoring division, one quotient bit per cycle; quotient shifts into num_ff
   always_comb begin
      trial = {rem_ff, num_ff[DIV_NUM_W-1]};
      take  = (trial >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            num_ff <= {num_ff[DIV_NUM_W-2:0], take};
            rem_ff <= take ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
            cnt_ff <= CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res = '{done: done_ff, quot: num_ff, rem: rem_ff};

endmodule

// File: design/distance_map_gradient_lookup_unit.sv
// Queries run the shared bit-serial divider twice (x, then y); a compute pass runs it twice per
// interior cell. Items are taken one at a time; the divider and the single read port of each map
// memory limit the rate. A result waiting in the output register does not block the next beat.
// Reset (synchronous) starts a sweep that clears all 2^(clog2(2*MAX_HALF_COLS)+clog2(2*MAX_HALF_ROWS))
// map addresses (16384 by default); req_stall stays high until it ends. CSR writes are taken throughout.
module distance_map_gradient_lookup_unit #(
   parameter int MAX_HALF_COLS = dmgl_pkg::DEF_MAX_HALF_COLS,
   parameter int MAX_HALF_ROWS = dmgl_pkg::DEF_MAX_HALF_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dmgl_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dmgl_pkg::rsp_type                rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dmgl_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import dmgl_pkg::*;

   // Cell (x,y) lives at address {y,x}: column and row index widths.
   localparam int CW    = $clog2(2 * MAX_HALF_COLS);
   localparam int RW    = $clog2(2 * MAX_HALF_ROWS);
   localparam int LW    = (CW > RW) ? CW : RW;
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;
   localparam logic [8:0] MAX_HC9 = 9'(MAX_HALF_COLS);
   localparam logic [8:0] MAX_HR9 = 9'(MAX_HALF_ROWS);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_U_RD, ST_U_WR,
      ST_Q_DIVX, ST_Q_DIVY, ST_Q_RD, ST_Q_OUT,
      ST_C_RD, ST_C_ACC, ST_C_DIVX, ST_C_DIVY, ST_C_WR,
      ST_B_RD, ST_B_WR,
      ST_K_RDA, ST_K_RDB, ST_K_WR,
      ST_DONE
   } state_type;

   // ---------------- configuration registers ----------------
   logic [6:0]  half_cols_ff;
   logic [6:0]  half_rows_ff;
   logic [9:0]  cell_size_ff;
   logic [15:0] outside_ff;

   logic [8:0]    hc_eff, hr_eff;
   logic [9:0]    w_eff, h_eff;
   logic [9:0]    c_eff;
   logic [CW-1:0] wm1, wm2;
   logic [RW-1:0] hm1, hm2;

   // out-of-range registers act as the nearest legal value
   always_comb begin
      hc_eff = (half_cols_ff < 7'd2) ? 9'd2 :
               (({2'b0, half_cols_ff} > MAX_HC9) ? MAX_HC9 : {2'b0, half_cols_ff});
      hr_eff = (half_rows_ff < 7'd2) ? 9'd2 :
               (({2'b0, half_rows_ff} > MAX_HR9) ? MAX_HR9 : {2'b0, half_rows_ff});
      w_eff  = {hc_eff, 1'b0};
      h_eff  = {hr_eff, 1'b0};
      c_eff  = (cell_size_ff == 10'd0) ? 10'd1 : cell_size_ff;
      wm1    = CW'(w_eff - 10'd1);
      wm2    = CW'(w_eff - 10'd2);
      hm1    = RW'(h_eff - 10'd1);
      hm2    = RW'(h_eff - 10'd2);
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_HALF_COLS: prdata = 32'(half_cols_ff);
         REG_HALF_ROWS: prdata = 32'(half_rows_ff);
         REG_CELL_SIZE: prdata = 32'(cell_size_ff);
         REG_OUTSIDE:   prdata = 32'(outside_ff);
         default:       prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // ---------------- map memories ----------------
   // distance map and gradient map {gx, gy}, one read and one write port each
   logic [15:0] dist_mem [DEPTH];
   logic [31:0] grad_mem [DEPTH];
   logic [15:0] dist_rd_ff;
   logic [31:0] grad_rd_ff;

   logic          dist_re, dist_we, grad_re, grad_we;
   logic [AW-1:0] dist_ra, dist_wa, grad_ra, grad_wa;
   logic [15:0]   dist_wd;
   logic [31:0]   grad_wd;

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      if (dist_re) dist_rd_ff <= dist_mem[dist_ra];
      if (grad_we) grad_mem[grad_wa] <= grad_wd;
      if (grad_re) grad_rd_ff <= grad_mem[grad_ra];
   end

   // ---------------- sequencer registers ----------------
   state_type          state_ff;
   logic [AW-1:0]      clr_ff;
   logic [CW-1:0]      ux_ff;
   logic [RW-1:0]      uy_ff;
   logic [15:0]        uval_ff;
   logic               ugrid_ff;
   logic signed [15:0] qx_ff, qy_ff;
   logic [CW-1:0]      xi_ff;
   logic [RW-1:0]      yi_ff;
   logic               xoff_ff, yoff_ff;
   logic [CW-1:0]      cx_ff;
   logic [RW-1:0]      cy_ff;
   logic [2:0]         k_ff;
   logic signed [19:0] gxs_ff, gys_ff;
   logic signed [15:0] gx_ff, gy_ff;
   logic               pend_ff;
   logic               side_ff;
   logic               bj_ff;
   logic [LW-1:0]      bi_ff;
   logic [1:0]         corner_ff;
   logic [31:0]        ga_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // ---------------- shared divider ----------------
   logic                 div_start;
   logic                 div_query;
   logic signed [19:0]   div_val;
   logic                 div_neg;
   logic [18:0]          div_mag;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   div_res_type          div_res;

   // Query: floor(pos / cell). Gradient: round(s*512/cell) = (|s|*1024 + c) / 2c.
   always_comb begin
      div_query = (state_ff == ST_Q_DIVX) || (state_ff == ST_Q_DIVY);
      unique case (state_ff)
         ST_Q_DIVX: div_val = 20'(qx_ff);
         ST_Q_DIVY: div_val = 20'(qy_ff);
         ST_C_DIVX: div_val = gxs_ff;
         default:   div_val = gys_ff;
      endcase
      div_neg   = div_val[19];
      div_mag   = div_neg ? 19'(-div_val) : div_val[18:0];
      div_num   = div_query ? DIV_NUM_W'(div_mag)
                            : ({div_mag, 10'b0} + DIV_NUM_W'(c_eff));
      div_den   = div_query ? {1'b0, c_eff} : {c_eff, 1'b0};
      div_start = !pend_ff && (div_query || (state_ff == ST_C_DIVX) ||
                               (state_ff == ST_C_DIVY));
   end

   dmgl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .res   (div_res)
   );

   // floor division result to a cell index, flag and clamp
   logic [16:0]        fl_q;
   logic [8:0]         fl_half;
   logic [9:0]         fl_span;
   logic signed [18:0] fl_fq, fl_idx, fl_lim;
   logic               fl_off;
   logic [LW-1:0]      fl_cl;

   always_comb begin
      fl_q    = div_res.quot[16:0];
      fl_half = (state_ff == ST_Q_DIVY) ? hr_eff : hc_eff;
      fl_span = (state_ff == ST_Q_DIVY) ? h_eff : w_eff;
      fl_fq   = div_neg ? (-$signed({2'b0, fl_q}) - $signed({18'b0, (div_res.rem != '0)}))
                        : $signed({2'b0, fl_q});
      fl_idx  = fl_fq + $signed({10'b0, fl_half});
      fl_lim  = $signed({9'b0, fl_span});
      fl_off  = (fl_idx < 0) || (fl_idx >= fl_lim);
      if (fl_idx < 0)            fl_cl = '0;
      else if (fl_idx >= fl_lim) fl_cl = LW'(fl_lim - 19'sd1);
      else                       fl_cl = LW'(fl_idx);
   end

   // rounded quotient to a saturated 16-bit gradient
   logic               sat_big;
   logic signed [15:0] sat_val;

   always_comb begin
      sat_big = |div_res.quot[DIV_NUM_W-1:15];
      if (div_neg) sat_val = sat_big ? 16'sh8000 : -$signed({1'b0, div_res.quot[14:0]});
      else         sat_val = sat_big ? 16'sh7FFF : $signed({1'b0, div_res.quot[14:0]});
   end

   // ---------------- Sobel neighbor walk ----------------
   // eight neighbor reads per interior cell with their x and y weights
   logic [CW-1:0]      ndx;
   logic [RW-1:0]      ndy;
   logic signed [2:0]  nwx, nwy;
   logic signed [19:0] nterm;

   always_comb begin
      unique case (k_ff)
         3'd0:    begin ndx = '1;     ndy = RW'(1); nwx = -3'sd1; nwy =  3'sd1; end
         3'd1:    begin ndx = '1;     ndy = '0;     nwx = -3'sd2; nwy =  3'sd0; end
         3'd2:    begin ndx = '1;     ndy = '1;     nwx = -3'sd1; nwy = -3'sd1; end
         3'd3:    begin ndx = CW'(1); ndy = RW'(1); nwx =  3'sd1; nwy =  3'sd1; end
         3'd4:    begin ndx = CW'(1); ndy = '0;     nwx =  3'sd2; nwy =  3'sd0; end
         3'd5:    begin ndx = CW'(1); ndy = '1;     nwx =  3'sd1; nwy = -3'sd1; end
         3'd6:    begin ndx = '0;     ndy = RW'(1); nwx =  3'sd0; nwy =  3'sd2; end
         default: begin ndx = '0;     ndy = '1;     nwx =  3'sd0; nwy = -3'sd2; end
      endcase
      nterm = $signed({4'b0, dist_rd_ff});
   end

   function automatic logic signed [19:0] wmul(logic signed [2:0] wt, logic signed [19:0] t);
      logic signed [19:0] r;
      unique case (wt)
         3'sd1:   r = t;
         3'sd2:   r = t <<< 1;
         -3'sd1:  r = -t;
         -3'sd2:  r = -(t <<< 1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // corner value: mean of two neighbors, ties away from zero
   function automatic logic signed [15:0] avg2(logic signed [15:0] a, logic signed [15:0] b);
      logic signed [16:0] s;
      logic [16:0]        m;
      logic [17:0]        q;
      s = 17'(a) + 17'(b);
      m = s[16] ? 17'(-s) : s[16:0];
      q = ({1'b0, m} + 18'd1) >> 1;
      return s[16] ? 16'(-$signed(q)) : 16'(q);
   endfunction

   // ---------------- border and corner addresses ----------------
   logic [AW-1:0] b_src, b_dst;
   logic [AW-1:0] k_dst, k_a, k_b;
   logic [LW-1:0] b_last;

   always_comb begin
      if (!side_ff) begin
         // top and bottom rows copy the row just inside
         b_dst  = {(bj_ff ? hm1 : RW'(0)), bi_ff[CW-1:0]};
         b_src  = {(bj_ff ? hm2 : RW'(1)), bi_ff[CW-1:0]};
         b_last = LW'(wm2);
      end else begin
         // left and right columns
         b_dst  = {bi_ff[RW-1:0], (bj_ff ? wm1 : CW'(0))};
         b_src  = {bi_ff[RW-1:0], (bj_ff ? wm2 : CW'(1))};
         b_last = LW'(hm2);
      end
      unique case (corner_ff)
         2'd0: begin
            k_dst = {RW'(0), CW'(0)}; k_a = {RW'(0), CW'(1)}; k_b = {RW'(1), CW'(0)};
         end
         2'd1: begin
            k_dst = {RW'(0), wm1};    k_a = {RW'(0), wm2};    k_b = {RW'(1), wm1};
         end
         2'd2: begin
            k_dst = {hm1, CW'(0)};    k_a = {hm2, CW'(0)};    k_b = {hm1, CW'(1)};
         end
         default: begin
            k_dst = {hm1, wm1};       k_a = {hm1, wm2};       k_b = {hm2, wm1};
         end
      endcase
   end

   // ---------------- memory port control ----------------
   always_comb begin
      dist_re = 1'b0; dist_ra = '0;
      dist_we = 1'b0; dist_wa = '0; dist_wd = '0;
      grad_re = 1'b0; grad_ra = '0;
      grad_we = 1'b0; grad_wa = '0; grad_wd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            dist_we = 1'b1; dist_wa = clr_ff; dist_wd = '1;
            grad_we = 1'b1; grad_wa = clr_ff; grad_wd = '0;
         end
         ST_U_RD: begin
            dist_re = 1'b1; dist_ra = {uy_ff, ux_ff};
         end
         ST_U_WR: begin
            // keep the smaller distance
            dist_we = ugrid_ff && (dist_rd_ff > uval_ff);
            dist_wa = {uy_ff, ux_ff};
            dist_wd = uval_ff;
         end
         ST_Q_RD: begin
            dist_re = 1'b1; dist_ra = {yi_ff, xi_ff};
            grad_re = 1'b1; grad_ra = {yi_ff, xi_ff};
         end
         ST_C_RD: begin
            dist_re = 1'b1; dist_ra = {cy_ff + ndy, cx_ff + ndx};
         end
         ST_C_WR: begin
            grad_we = 1'b1; grad_wa = {cy_ff, cx_ff}; grad_wd = {gx_ff, gy_ff};
         end
         ST_B_RD: begin
            grad_re = 1'b1; grad_ra = b_src;
         end
         ST_B_WR: begin
            grad_we = 1'b1; grad_wa = b_dst; grad_wd = grad_rd_ff;
         end
         ST_K_RDA: begin
            grad_re = 1'b1; grad_ra = k_a;
         end
         ST_K_RDB: begin
            grad_re = 1'b1; grad_ra = k_b;
         end
         ST_K_WR: begin
            grad_we = 1'b1; grad_wa = k_dst;
            grad_wd = {avg2(ga_ff[31:16], grad_rd_ff[31:16]),
                       avg2(ga_ff[15:0], grad_rd_ff[15:0])};
         end
         default: ;
      endcase
   end

   // ---------------- sequencer ----------------
   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         half_cols_ff <= RST_HALF_COLS;
         half_rows_ff <= RST_HALF_ROWS;
         cell_size_ff <= RST_CELL_SIZE;
         outside_ff   <= RST_OUTSIDE;
      end else begin
         // CSR write in the access phase
         if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
               REG_HALF_COLS: half_cols_ff <= pwdata[6:0];
               REG_HALF_ROWS: half_rows_ff <= pwdata[6:0];
               REG_CELL_SIZE: cell_size_ff <= pwdata[9:0];
               REG_OUTSIDE:   outside_ff   <= pwdata[15:0];
               default: ;
            endcase
         end

         // output register: load a finished item, clear once the beat is taken
         if (((state_ff == ST_Q_OUT) || (state_ff == ST_DONE)) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= AW'(clr_ff + 1'b1);
               if (clr_ff == '1) state_ff <= ST_IDLE;
            end

            ST_IDLE: begin
               if (req_valid) begin
                  ux_ff    <= CW'(req_data.col);
                  uy_ff    <= RW'(req_data.row);
                  uval_ff  <= req_data.cell_distance;
                  qx_ff    <= req_data.pos_x;
                  qy_ff    <= req_data.pos_y;
                  ugrid_ff <= 1'b0;
                  pend_ff  <= 1'b0;
                  cx_ff    <= CW'(1);
                  cy_ff    <= RW'(1);
                  k_ff     <= '0;
                  gxs_ff   <= '0;
                  gys_ff   <= '0;
                  unique case (req_data.kind)
                     KIND_UPDATE: begin
                        ugrid_ff <= ({3'b0, req_data.col} < w_eff) &&
                                    ({3'b0, req_data.row} < h_eff);
                        state_ff <= ST_U_RD;
                     end
                     KIND_COMPUTE: state_ff <= ST_C_RD;
                     KIND_QUERY:   state_ff <= ST_Q_DIVX;
                     default:      state_ff <= ST_U_RD;  // unused kind: no write, no beat
                  endcase
               end
            end

            ST_U_RD: state_ff <= ST_U_WR;
            ST_U_WR: state_ff <= ST_IDLE;

            ST_Q_DIVX: begin
               if (!pend_ff) pend_ff <= 1'b1;
               else if (div_res.done) begin
                  pend_ff  <= 1'b0;
                  xi_ff    <= fl_cl[CW-1:0];
                  xoff_ff  <= fl_off;
                  state_ff <= ST_Q_DIVY;
               end
            end

            ST_Q_DIVY: begin
               if (!pend_ff) pend_ff <= 1'b1;
               else if (div_res.done) begin
                  pend_ff  <= 1'b0;
                  yi_ff    <= fl_cl[RW-1:0];
                  yoff_ff  <= fl_off;
                  state_ff <= ST_Q_RD;
               end
            end

            ST_Q_RD: state_ff <= ST_Q_OUT;

            ST_Q_OUT: begin
               if (out_free) begin
                  // off-grid points report the outside distance, gradient of the clamped cell
                  rsp_data_ff.distance <= (xoff_ff || yoff_ff) ? outside_ff : dist_rd_ff;
                  rsp_data_ff.grad_x   <= grad_rd_ff[31:16];
                  rsp_data_ff.grad_y   <= grad_rd_ff[15:0];
                  rsp_data_ff.outside  <= xoff_ff || yoff_ff;
                  rsp_data_ff.done_res <= 1'b0;
                  state_ff             <= ST_IDLE;
               end
            end

            ST_C_RD: state_ff <= ST_C_ACC;

            ST_C_ACC: begin
               gxs_ff <= gxs_ff + wmul(nwx, nterm);
               gys_ff <= gys_ff + wmul(nwy, nterm);
               k_ff   <= k_ff + 3'd1;
               state_ff <= (k_ff == 3'd7) ? ST_C_DIVX : ST_C_RD;
            end

            ST_C_DIVX: begin
               if (!pend_ff) pend_ff <= 1'b1;
               else if (div_res.done) begin
                  pend_ff  <= 1'b0;
                  gx_ff    <= sat_val;
                  state_ff <= ST_C_DIVY;
               end
            end

            ST_C_DIVY: begin
               if (!pend_ff) pend_ff <= 1'b1;
               else if (div_res.done) begin
                  pend_ff  <= 1'b0;
                  gy_ff    <= sat_val;
                  state_ff <= ST_C_WR;
               end
            end

            ST_C_WR: begin
               gxs_ff <= '0;
               gys_ff <= '0;
               k_ff   <= '0;
               if (cx_ff == wm2) begin
                  cx_ff <= CW'(1);
                  if (cy_ff == hm2) begin
                     side_ff  <= 1'b0;
                     bi_ff    <= LW'(1);
                     bj_ff    <= 1'b0;
                     state_ff <= ST_B_RD;
                  end else begin
                     cy_ff    <= cy_ff + RW'(1);
                     state_ff <= ST_C_RD;
                  end
               end else begin
                  cx_ff    <= cx_ff + CW'(1);
                  state_ff <= ST_C_RD;
               end
            end

            ST_B_RD: state_ff <= ST_B_WR;

            ST_B_WR: begin
               if (!bj_ff) begin
                  bj_ff    <= 1'b1;
                  state_ff <= ST_B_RD;
               end else begin
                  bj_ff <= 1'b0;
                  if (bi_ff == b_last) begin
                     bi_ff <= LW'(1);
                     if (!side_ff) begin
                        side_ff  <= 1'b1;
                        state_ff <= ST_B_RD;
                     end else begin
                        corner_ff <= '0;
                        state_ff  <= ST_K_RDA;
                     end
                  end else begin
                     bi_ff    <= bi_ff + LW'(1);
                     state_ff <= ST_B_RD;
                  end
               end
            end

            ST_K_RDA: state_ff <= ST_K_RDB;

            ST_K_RDB: begin
               ga_ff    <= grad_rd_ff;
               state_ff <= ST_K_WR;
            end

            ST_K_WR: begin
               corner_ff <= corner_ff + 2'd1;
               state_ff  <= (corner_ff == 2'd3) ? ST_DONE : ST_K_RDA;
            end

            ST_DONE: begin
               if (out_free) begin
                  rsp_data_ff.distance <= '0;
                  rsp_data_ff.grad_x   <= '0;
                  rsp_data_ff.grad_y   <= '0;
                  rsp_data_ff.outside  <= 1'b0;
                  rsp_data_ff.done_res <= 1'b1;
                  state_ff             <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/dmgl_checker.sv
module dmgl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dmgl_pkg::rsp_type rsp_data
);
   import dmgl_pkg::*;

   // clearing sweep follows reset: no beat taken right after it
   a_reset_stall: assert property (@(posedge clock) $past(reset) |-> req_stall)
      else $error("input taken right after reset");

   // every accepted beat leaves the sequencer busy, so the input stalls in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |->
      (rsp_data.distance == 16'd0 && !rsp_data.outside &&
       rsp_data.grad_x == 16'sd0 && rsp_data.grad_y == 16'sd0))
      else $error("compute result carries payload");

endmodule

bind distance_map_gradient_lookup_unit dmgl_checker u_dmgl_checker (.*);

// File: test/tb_distance_map_gradient_lookup_unit.sv
`timescale 1ns / 100ps
module tb_distance_map_gradient_lookup_unit;
   import dmgl_pkg::*;

   localparam int STRIDE      = 2 * DEF_MAX_HALF_COLS;
   localparam int DEPTH       = STRIDE * 2 * DEF_MAX_HALF_ROWS;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int ITEM_GOAL   = 1150;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // predictor copy of the map and the registers
   logic [15:0]        dist_map [DEPTH];
   logic signed [15:0] gx_map   [DEPTH];
   logic signed [15:0] gy_map   [DEPTH];
   int                 cfg_half_cols, cfg_half_rows, cfg_cell, cfg_outside;

   rsp_type pending_results[$];
   int      errors     = 0;
   int      items_sent = 0;
   int      cycles     = 0;
   bit      idle_on    = 1'b1;   // random gaps and stalls
   bit      hold_req   = 1'b0;   // ask receiver for a long hold-off
   int      hold_left  = 0;

   distance_map_gradient_lookup_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic int eff_half(int v);
      if (v < 2) return 2;
      if (v > 64) return 64;
      return v;
   endfunction

   function automatic int eff_cell();
      return (cfg_cell == 0) ? 1 : cfg_cell;
   endfunction

   // Sobel sum to 12-bit fraction: s*512/c, round half away, saturate
   function automatic logic signed [15:0] scale_grad(longint s, longint c);
      longint mag, q;
      mag = (s < 0) ? -s : s;
      q = (mag * 1024 + c) / (2 * c);
      if (s < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic logic signed [15:0] avg_pair(int a, int b);
      int s, mag, q;
      s = a + b;
      mag = (s < 0) ? -s : s;
      q = (mag + 1) / 2;
      s = (s < 0) ? -q : q;
      return s[15:0];
   endfunction

   function automatic int floor_div(int x, int c);
      int q;
      q = x / c;
      if ((x % c) != 0 && x < 0) q--;
      return q;
   endfunction

   task automatic copy_cell(int dst, int src);
      gx_map[dst] = gx_map[src];
      gy_map[dst] = gy_map[src];
   endtask

   task automatic avg_cell(int dst, int a, int b);
      gx_map[dst] = avg_pair(gx_map[a], gx_map[b]);
      gy_map[dst] = avg_pair(gy_map[a], gy_map[b]);
   endtask

   task automatic sobel_pass();
      int w, h, c, m;
      longint lo, lm, lu, ro, rm, ru, mo, mu;
      w = 2 * eff_half(cfg_half_cols);
      h = 2 * eff_half(cfg_half_rows);
      c = eff_cell();
      for (int x = 1; x + 1 < w; x++)
         for (int y = 1; y + 1 < h; y++) begin
            m  = x + STRIDE * y;
            lo = dist_map[m - 1 + STRIDE]; lm = dist_map[m - 1]; lu = dist_map[m - 1 - STRIDE];
            ro = dist_map[m + 1 + STRIDE]; rm = dist_map[m + 1]; ru = dist_map[m + 1 - STRIDE];
            mo = dist_map[m + STRIDE];     mu = dist_map[m - STRIDE];
            gx_map[m] = scale_grad(-lo + ro - 2 * lm + 2 * rm - lu + ru, c);
            gy_map[m] = scale_grad(lo - lu + 2 * mo - 2 * mu + ro - ru, c);
         end
      // borders copy the inner neighbor
      for (int x = 1; x + 1 < w; x++) begin
         copy_cell(x, x + STRIDE);
         copy_cell(x + STRIDE * (h - 1), x + STRIDE * (h - 2));
      end
      for (int y = 1; y + 1 < h; y++) begin
         copy_cell(STRIDE * y, STRIDE * y + 1);
         copy_cell(STRIDE * y + w - 1, STRIDE * y + w - 2);
      end
      // each corner averages its row neighbor and its column neighbor on the edges
      avg_cell(0, 1, STRIDE);
      avg_cell(w - 1, w - 2, STRIDE + w - 1);
      avg_cell(STRIDE * (h - 1), STRIDE * (h - 2), STRIDE * (h - 1) + 1);
      avg_cell(STRIDE * (h - 1) + w - 1, STRIDE * (h - 1) + w - 2, STRIDE * (h - 2) + w - 1);
   endtask

   task automatic predict_item(req_type d);
      int hc, hr, w, h, c, xi, yi, a;
      bit off;
      rsp_type r;
      hc = eff_half(cfg_half_cols);
      hr = eff_half(cfg_half_rows);
      w = 2 * hc;
      h = 2 * hr;
      r = '0;
      case (d.kind)
         KIND_UPDATE: begin
            if (d.col < w && d.row < h) begin
               a = d.col + STRIDE * d.row;
               if (dist_map[a] > d.cell_distance) dist_map[a] = d.cell_distance;
            end
         end
         KIND_COMPUTE: begin
            sobel_pass();
            r.done_res = 1'b1;
            pending_results.push_back(r);
         end
         KIND_QUERY: begin
            c  = eff_cell();
            xi = floor_div(int'(d.pos_x), c) + hc;
            yi = floor_div(int'(d.pos_y), c) + hr;
            off = (xi < 0 || yi < 0 || xi >= w || yi >= h);
            if (off) r.distance = cfg_outside[15:0];
            else r.distance = dist_map[xi + STRIDE * yi];
            // gradient always from the clamped cell
            if (xi < 0) xi = 0;
            if (xi >= w) xi = w - 1;
            if (yi < 0) yi = 0;
            if (yi >= h) yi = h - 1;
            r.grad_x  = gx_map[xi + STRIDE * yi];
            r.grad_y  = gy_map[xi + STRIDE * yi];
            r.outside = off;
            pending_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   // ---------------- result checker ----------------
   task automatic check_result(rsp_type got);
      rsp_type exp_r;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result beat %h", $realtime, got);
         errors++;
      end else begin
         exp_r = pending_results.pop_front();
         if (got.distance !== exp_r.distance) begin
            $display("%0t: distance exp %0d got %0d", $realtime, exp_r.distance, got.distance);
            errors++;
         end
         if (got.grad_x !== exp_r.grad_x) begin
            $display("%0t: grad_x exp %0d got %0d", $realtime, exp_r.grad_x, got.grad_x);
            errors++;
         end
         if (got.grad_y !== exp_r.grad_y) begin
            $display("%0t: grad_y exp %0d got %0d", $realtime, exp_r.grad_y, got.grad_y);
            errors++;
         end
         if (got.outside !== exp_r.outside) begin
            $display("%0t: outside exp %0b got %0b", $realtime, exp_r.outside, got.outside);
            errors++;
         end
         if (got.done_res !== exp_r.done_res) begin
            $display("%0t: done_res exp %0b got %0b", $realtime, exp_r.done_res, got.done_res);
            errors++;
         end
      end
   endtask

   // receiver: checks accepted beats, drives random stalls and the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result(rsp_data);
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 9);
      end
   end

   // ---------------- drivers ----------------
   // all driver tasks start and end right after a rising edge
   task automatic send_item(req_type d);
      int gap;
      if (idle_on && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(d);
      if (d.kind != KIND_UNUSED) items_sent++;
   endtask

   // wait for every result, then let trailing update beats settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);   // write lands at this edge
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_HALF_COLS: cfg_half_cols = int'(value[6:0]);
         REG_HALF_ROWS: cfg_half_rows = int'(value[6:0]);
         REG_CELL_SIZE: cfg_cell      = int'(value[9:0]);
         REG_OUTSIDE:   cfg_outside   = int'(value[15:0]);
         default: ;
      endcase
   endtask

   task automatic set_grid(int hc, int hr, int cs, int od);
      csr_write(REG_HALF_COLS, hc);
      csr_write(REG_HALF_ROWS, hr);
      csr_write(REG_CELL_SIZE, cs);
      csr_write(REG_OUTSIDE, od);
   endtask

   function automatic req_type mk_update(int col, int row, int cell_dist);
      req_type d;
      d = req_type'({$urandom, $urandom});   // unused fields carry noise
      d.kind = KIND_UPDATE;
      d.col = 7'(col);
      d.row = 7'(row);
      d.cell_distance = 16'(cell_dist);
      return d;
   endfunction

   function automatic req_type mk_query(int px, int py);
      req_type d;
      d = req_type'({$urandom, $urandom});
      d.kind  = KIND_QUERY;
      d.pos_x = 16'(px);
      d.pos_y = 16'(py);
      return d;
   endfunction

   function automatic req_type mk_kind(logic [1:0] k);
      req_type d;
      d = req_type'({$urandom, $urandom});
      d.kind = k;
      return d;
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      // reset grid 128x128, cell 50
      send_item(mk_query(0, 0));
      send_item(mk_query(-32768, -32768));     // far off grid, low corner clamp
      send_item(mk_query(32767, 32767));       // far off grid, high corner clamp
      send_item(mk_update(0, 0, 0));
      send_item(mk_update(127, 127, 0));
      send_item(mk_update(5, 5, 65535));       // no change on a max map
      send_item(mk_query(-3200, -3200));       // lands on cell (0,0)
      send_item(mk_query(3199, 3199));         // cell (127,127)
      send_item(mk_query(-1, 0));              // floor on negative coordinate
      send_item(mk_kind(KIND_UNUSED));
      drain();
      // smallest grid, unit cells: saturated gradients
      set_grid(2, 2, 1, 0);
      send_item(mk_update(4, 0, 7));           // column off grid
      send_item(mk_update(0, 4, 7));           // row off grid
      send_item(mk_update(3, 3, 0));
      send_item(mk_update(0, 1, 100));
      send_item(mk_update(2, 1, 65535));
      send_item(mk_kind(KIND_COMPUTE));
      send_item(mk_query(-2, -2));             // corner
      send_item(mk_query(1, -1));
      send_item(mk_query(-3, 0));              // off left, outside value 0
      send_item(mk_query(2, 1));               // off right
      drain();
      csr_write(REG_OUTSIDE, 65535);
      send_item(mk_query(0, -3));
      send_item(mk_query(1, 1));
      drain();
   endtask

   task automatic test_config_extremes();
      // below-minimum and above-maximum sizes, zero and max cell size
      set_grid(0, 127, 0, 12345);
      send_item(mk_update(1, 60, 3));
      send_item(mk_kind(KIND_COMPUTE));
      send_item(mk_query(-2, 63));
      send_item(mk_query(1, -65));
      drain();
      set_grid(127, 1, 1023, 1);
      send_item(mk_update(100, 2, 9));
      send_item(mk_kind(KIND_COMPUTE));
      send_item(mk_query(32767, -32768));
      send_item(mk_query(-20000, 1000));
      drain();
   endtask

   task automatic random_phase(bit large_cols, bit large_rows);
      int hc, hr, cs, w, h, n_upd, n_qry, sel, col, row, px, py;
      req_type d;
      hc = large_cols ? $urandom_range(0, 127) : $urandom_range(0, 6);
      hr = large_rows ? $urandom_range(0, 127) : $urandom_range(0, 6);
      sel = $urandom_range(4);
      case (sel)
         0: cs = 1;
         1: cs = 0;
         2: cs = 1023;
         3: cs = $urandom_range(1, 20);
         default: cs = $urandom_range(1, 1023);
      endcase
      set_grid(hc, hr, cs, $urandom_range(0, 65535));
      hc = eff_half(cfg_half_cols);
      hr = eff_half(cfg_half_rows);
      w = 2 * hc;
      h = 2 * hr;
      cs = eff_cell();
      n_upd = $urandom_range(4, 20);
      for (int i = 0; i < n_upd; i++) begin
         if ($urandom_range(99) < 85) begin
            col = $urandom_range(0, w - 1);
            row = $urandom_range(0, h - 1);
         end else begin
            col = $urandom_range(0, 127);
            row = $urandom_range(0, 127);
         end
         sel = $urandom_range(3);
         send_item(mk_update(col, row, sel == 0 ? $urandom_range(0, 65535) :
                                       sel == 1 ? 0 : $urandom_range(0, 3000)));
         if ($urandom_range(99) < 5) send_item(mk_kind(KIND_UNUSED));
      end
      send_item(mk_kind(KIND_COMPUTE));
      n_qry = $urandom_range(5, 15);
      for (int i = 0; i < n_qry; i++) begin
         if ($urandom_range(99) < 20) begin
            d = mk_kind(KIND_QUERY);             // full 16-bit positions
         end else begin
            px = ($urandom_range(0, w + 1) - hc - 1) * cs + $urandom_range(0, cs - 1);
            py = ($urandom_range(0, h + 1) - hr - 1) * cs + $urandom_range(0, cs - 1);
            d = mk_query(px, py);
         end
         send_item(d);
         if ($urandom_range(99) < 5) send_item(mk_kind(KIND_UNUSED));
      end
      drain();
   endtask

   task automatic test_random();
      int phase;
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         idle_on = !(phase >= 6 && phase < 10);   // a stretch with no gaps or stalls
         random_phase(phase % 9 == 3, phase % 9 == 7);
         phase++;
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      set_grid(4, 4, 10, 77);
      idle_on  = 1'b0;
      hold_req = 1'b1;   // receiver holds off while queries keep coming
      for (int i = 0; i < 20; i++)
         send_item(mk_query($urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50));
      idle_on = 1'b1;
      drain();
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         dist_map[i] = 16'hFFFF;
         gx_map[i]   = '0;
         gy_map[i]   = '0;
      end
      cfg_half_cols = int'(RST_HALF_COLS);
      cfg_half_rows = int'(RST_HALF_ROWS);
      cfg_cell      = int'(RST_CELL_SIZE);
      cfg_outside   = int'(RST_OUTSIDE);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random();

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
